// ===== src/wcm_pkg.sv =====
package wcm_pkg;

  localparam int unsigned CHANNELS_DEF         = 8;
  localparam int unsigned SAMPLE_ADDR_BITS_DEF = 16;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CHAN_W  = 3;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned END_W   = 17;
  localparam int unsigned STEP_W  = 18;
  localparam int unsigned VOL_W   = 7;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned SMPL_W  = 16;

  // floor(n / 127) == (n * DIV127_MAGIC) >> DIV127_SHIFT for n < 2**15
  localparam logic [15:0] DIV127_MAGIC = 16'd33027;
  localparam int unsigned DIV127_SHIFT = 22;

  localparam logic [8:0] SAMPLE_MID = 9'd128;
  localparam int         SAT_MAX    = 32767;
  localparam int         SAT_MIN    = -32768;

  typedef enum logic [CMD_W-1:0] {
    CMD_MIX   = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_START = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAN_W-1:0] chan;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [END_W-1:0]  end_addr;
    logic [STEP_W-1:0] step;
    logic [VOL_W-1:0]  left_vol;
    logic [VOL_W-1:0]  right_vol;
  } req_item_t;

  typedef struct packed {
    logic accept;    // request taken this cycle
    logic clear;     // zero the mix sums
    logic issue;     // process the channel under the counter
    logic load_out;  // saturate sums into the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_chan;
  } ctrl_sts_t;

endpackage

// ===== src/wcm_req_if.sv =====
interface wcm_req_if;
  import wcm_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CHAN_W-1:0] chan;
  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] data;
  logic [END_W-1:0]  end_addr;
  logic [STEP_W-1:0] step;
  logic [VOL_W-1:0]  left_vol;
  logic [VOL_W-1:0]  right_vol;

  modport source (
    output valid, cmd, chan, addr, data, end_addr, step, left_vol, right_vol,
    input  ready
  );

  modport sink (
    input  valid, cmd, chan, addr, data, end_addr, step, left_vol, right_vol,
    output ready
  );
endinterface

// ===== src/wcm_res_if.sv =====
interface wcm_res_if;
  import wcm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [SMPL_W-1:0] left_sample;
  logic signed [SMPL_W-1:0] right_sample;

  modport source (
    output valid, left_sample, right_sample,
    input  ready
  );

  modport sink (
    input  valid, left_sample, right_sample,
    output ready
  );
endinterface

// ===== src/wcm_ctrl.sv =====
module wcm_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  input  logic [wcm_pkg::CMD_W-1:0]    req_cmd_i,
  output logic                         req_ready_o,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  input  wcm_pkg::ctrl_sts_t           sts_i,
  output wcm_pkg::ctrl_cmd_t           cmd_o
);
  import wcm_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] drain_q, drain_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign accept      = req_valid_i && req_ready_o;
  assign res_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      drain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    drain_d     = drain_q;
    out_valid_d = out_valid_q && !res_ready_i;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    cmd_o.accept = accept;

    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (accept && req_cmd_i == CMD_MIX) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_MIX;
        end
      end
      ST_MIX: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_chan) begin
          drain_d = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the scaling pipeline to empty
        drain_d = drain_q + 2'd1;
        if (drain_q == 2'd2) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || res_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/wcm_datapath.sv =====
module wcm_datapath #(
  parameter int unsigned CHANNELS         = wcm_pkg::CHANNELS_DEF,
  parameter int unsigned SAMPLE_ADDR_BITS = wcm_pkg::SAMPLE_ADDR_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  wcm_pkg::req_item_t                item_i,
  input  wcm_pkg::ctrl_cmd_t                cmd_i,
  output wcm_pkg::ctrl_sts_t                sts_o,
  output logic signed [wcm_pkg::SMPL_W-1:0] left_sample_o,
  output logic signed [wcm_pkg::SMPL_W-1:0] right_sample_o
);
  import wcm_pkg::*;

  localparam int unsigned AW        = SAMPLE_ADDR_BITS;
  localparam int unsigned PW        = SAMPLE_ADDR_BITS + 1;
  localparam int unsigned MEM_DEPTH = 2 ** SAMPLE_ADDR_BITS;
  localparam int unsigned CW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SUM_W     = 18 + CW;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(SAT_MAX);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(SAT_MIN);

  // sample store and channel table
  logic [DATA_W-1:0] mem_q [MEM_DEPTH];
  logic [DATA_W-1:0] rdata_q;

  logic [CHANNELS-1:0] act_q;
  logic [PW-1:0]     pos_q  [CHANNELS];
  logic [PW-1:0]     end_q  [CHANNELS];
  logic [FRAC_W-1:0] frac_q [CHANNELS];
  logic [STEP_W-1:0] step_q [CHANNELS];
  logic [VOL_W-1:0]  vl_q   [CHANNELS];
  logic [VOL_W-1:0]  vr_q   [CHANNELS];

  logic [CW-1:0]     cnt_q;
  logic              last_chan;

  logic              is_load, is_start, start_ok;
  logic [7:0]        chan_ext;
  logic [CW-1:0]     start_idx;

  logic [FRAC_W+2:0] frac_sum;
  logic [PW-1:0]     pos_next;

  // scaling pipeline
  logic                     s1_valid_q, s2_valid_q, s3_valid_q;
  logic [VOL_W-1:0]         s1_vl_q, s1_vr_q;
  logic signed [8:0]        s1_centered;
  logic signed [16:0]       s1_pl, s1_pr;
  logic signed [16:0]       s2_pl_q, s2_pr_q;
  logic [16:0]              s2_ml, s2_mr;
  logic [14:0]              s2_nl, s2_nr;
  logic [30:0]              s2_prod_l, s2_prod_r;
  logic [14:0]              s3_nl_q, s3_nr_q;
  logic [30:0]              s3_prod_l_q, s3_prod_r_q;
  logic                     s3_neg_l_q, s3_neg_r_q;
  logic [15:0]              s3_ql, s3_qr;
  logic signed [SUM_W-1:0]  s3_tl, s3_tr, s3_cl, s3_cr;
  logic signed [SUM_W-1:0]  sum_l_q, sum_r_q;

  assign is_load   = cmd_i.accept && item_i.cmd == CMD_LOAD;
  assign is_start  = cmd_i.accept && item_i.cmd == CMD_START;
  assign chan_ext  = 8'(item_i.chan);
  assign start_idx = chan_ext[CW-1:0];
  assign start_ok  = 32'(item_i.chan) < CHANNELS;

  assign last_chan       = cnt_q == CW'(CHANNELS - 1);
  assign sts_o.last_chan = last_chan;

  // channel advance: carry of the fraction moves the position
  assign frac_sum = {3'b000, frac_q[cnt_q]} + {1'b0, step_q[cnt_q]};
  assign pos_next = pos_q[cnt_q] + PW'(frac_sum[FRAC_W+2:FRAC_W]);

  always_ff @(posedge clk_i) begin
    if (is_load) begin
      mem_q[AW'(item_i.addr)] <= item_i.data;
    end
    rdata_q <= mem_q[pos_q[cnt_q][AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        act_q[i] <= 1'b0;
      end
    end else begin
      if (is_start && start_ok) begin
        act_q[start_idx] <= 1'b1;
      end else if (cmd_i.issue && act_q[cnt_q]) begin
        act_q[cnt_q] <= pos_next < end_q[cnt_q];
      end
      if (cmd_i.issue) begin
        cnt_q <= last_chan ? '0 : cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_start && start_ok) begin
      pos_q[start_idx]  <= {1'b0, AW'(item_i.addr)};
      end_q[start_idx]  <= PW'(item_i.end_addr);
      frac_q[start_idx] <= '0;
      step_q[start_idx] <= item_i.step;
      vl_q[start_idx]   <= item_i.left_vol;
      vr_q[start_idx]   <= item_i.right_vol;
    end else if (cmd_i.issue && act_q[cnt_q]) begin
      pos_q[cnt_q]  <= pos_next;
      frac_q[cnt_q] <= frac_sum[FRAC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.issue && act_q[cnt_q];
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // stage 1: volume times centered byte
  assign s1_centered = $signed({1'b0, rdata_q}) - $signed(SAMPLE_MID);
  assign s1_pl       = $signed({1'b0, s1_vl_q}) * s1_centered;
  assign s1_pr       = $signed({1'b0, s1_vr_q}) * s1_centered;

  // stage 2: |p|*256/127 = 2|p| + floor(2|p|/127), reciprocal multiply
  assign s2_ml     = s2_pl_q[16] ? 17'(-s2_pl_q) : 17'(s2_pl_q);
  assign s2_mr     = s2_pr_q[16] ? 17'(-s2_pr_q) : 17'(s2_pr_q);
  assign s2_nl     = {s2_ml[13:0], 1'b0};
  assign s2_nr     = {s2_mr[13:0], 1'b0};
  assign s2_prod_l = {16'b0, s2_nl} * {15'b0, DIV127_MAGIC};
  assign s2_prod_r = {16'b0, s2_nr} * {15'b0, DIV127_MAGIC};

  // stage 3: restore sign (truncated toward zero) and accumulate
  assign s3_ql = {1'b0, s3_nl_q} + 16'(s3_prod_l_q[30:DIV127_SHIFT]);
  assign s3_qr = {1'b0, s3_nr_q} + 16'(s3_prod_r_q[30:DIV127_SHIFT]);
  assign s3_tl = $signed({{(SUM_W-16){1'b0}}, s3_ql});
  assign s3_tr = $signed({{(SUM_W-16){1'b0}}, s3_qr});
  assign s3_cl = s3_neg_l_q ? -s3_tl : s3_tl;
  assign s3_cr = s3_neg_r_q ? -s3_tr : s3_tr;

  always_ff @(posedge clk_i) begin
    s1_vl_q     <= vl_q[cnt_q];
    s1_vr_q     <= vr_q[cnt_q];
    s2_pl_q     <= s1_pl;
    s2_pr_q     <= s1_pr;
    s3_nl_q     <= s2_nl;
    s3_nr_q     <= s2_nr;
    s3_prod_l_q <= s2_prod_l;
    s3_prod_r_q <= s2_prod_r;
    s3_neg_l_q  <= s2_pl_q[16];
    s3_neg_r_q  <= s2_pr_q[16];

    if (cmd_i.clear) begin
      sum_l_q <= '0;
      sum_r_q <= '0;
    end else if (s3_valid_q) begin
      sum_l_q <= sum_l_q + s3_cl;
      sum_r_q <= sum_r_q + s3_cr;
    end

    if (cmd_i.load_out) begin
      if (sum_l_q > SAT_HI) begin
        left_sample_o <= SMPL_W'(SAT_MAX);
      end else if (sum_l_q < SAT_LO) begin
        left_sample_o <= SMPL_W'(SAT_MIN);
      end else begin
        left_sample_o <= sum_l_q[SMPL_W-1:0];
      end
      if (sum_r_q > SAT_HI) begin
        right_sample_o <= SMPL_W'(SAT_MAX);
      end else if (sum_r_q < SAT_LO) begin
        right_sample_o <= SMPL_W'(SAT_MIN);
      end else begin
        right_sample_o <= sum_r_q[SMPL_W-1:0];
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue && last_chan |=> cnt_q == '0)
    else $error("channel counter did not wrap after the last channel");

  a_pipe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> $past(s2_valid_q))
    else $error("scaling pipeline stage 3 valid without stage 2");

  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !s1_valid_q && !s2_valid_q && !s3_valid_q)
    else $error("result loaded while the pipeline still holds channels");

  a_no_new_voice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue && !cmd_i.accept |=>
      $countones(act_q) <= $past($countones(act_q)))
    else $error("a channel became active during a mix");
`endif

endmodule

// ===== src/wavetable_channel_mixer.sv =====
// Wavetable channel mixer: sample memory plus CHANNELS playback voices.
//
// req_i carries one request per valid/ready handshake: load a sample byte,
// start a channel, or mix one stereo tick. res_o returns one stereo result
// per mix request; load and start requests return nothing.
//
// Load and start requests complete on acceptance, and the next request is
// accepted in the following cycle. A mix request walks the channel table,
// one channel per cycle through the shared sample memory read port, followed
// by a three-stage scaling pipeline, and req_i stays low-ready from the
// accept until the result is loaded into the output register.
//
// The result sits in an output register. Further load and start requests,
// and the next mix walk, proceed while it waits; a finished mix holds in its
// last state until res_o has room.
//
// Reset clears all channel active flags, the output valid and the
// sequencer. The sample memory is not cleared and must be loaded before a
// channel plays from it; there is no clearing pass after reset.
module wavetable_channel_mixer #(
  parameter int unsigned CHANNELS         = wcm_pkg::CHANNELS_DEF,
  parameter int unsigned SAMPLE_ADDR_BITS = wcm_pkg::SAMPLE_ADDR_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wcm_req_if.sink   req_i,
  wcm_res_if.source res_o
);
  import wcm_pkg::*;

  req_item_t item;
  ctrl_cmd_t ctrl_cmd;
  ctrl_sts_t ctrl_sts;

  assign item.cmd       = req_i.cmd;
  assign item.chan      = req_i.chan;
  assign item.addr      = req_i.addr;
  assign item.data      = req_i.data;
  assign item.end_addr  = req_i.end_addr;
  assign item.step      = req_i.step;
  assign item.left_vol  = req_i.left_vol;
  assign item.right_vol = req_i.right_vol;

  wcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_cmd_i   (req_i.cmd),
    .req_ready_o (req_i.ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .sts_i       (ctrl_sts),
    .cmd_o       (ctrl_cmd)
  );

  wcm_datapath #(
    .CHANNELS         (CHANNELS),
    .SAMPLE_ADDR_BITS (SAMPLE_ADDR_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item),
    .cmd_i          (ctrl_cmd),
    .sts_o          (ctrl_sts),
    .left_sample_o  (res_o.left_sample),
    .right_sample_o (res_o.right_sample)
  );

endmodule
